// ----- rtl/tohlc_pkg.sv -----
// ----------------------------------------------------------------------------
// tohlc_pkg: shared types and constants of the tick to ohlc bar aggregator
// widths of time, price and volume, register indexes, price source codes and
// the request / response bundles of the remainder unit
// ----------------------------------------------------------------------------
package tohlc_pkg;

  localparam int unsigned TimeW   = 48;
  localparam int unsigned PriceW  = 32;
  localparam int unsigned TickVolW = 32;
  localparam int unsigned BarVolW = 48;
  localparam int unsigned PeriodW = 32;
  localparam int unsigned SrcW    = 2;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CfgBarPeriod   = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgPriceSource = 1'd1;

  localparam logic [PeriodW-1:0] PeriodReset = 32'd60000;

  typedef enum logic [SrcW-1:0] {
    SRC_LAST = 2'd0,
    SRC_MID  = 2'd1,
    SRC_BID  = 2'd2,
    SRC_ASK  = 2'd3
  } src_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_APPLY,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic               start;
    logic [TimeW-1:0]   dividend;
    logic [PeriodW-1:0] divisor;
  } rem_req_t;

  typedef struct packed {
    logic               done;
    logic [PeriodW-1:0] rem;
  } rem_rsp_t;

endpackage

// ----- rtl/tohlc_rem.sv -----
// ----------------------------------------------------------------------------
// tohlc_rem: iterative remainder unit
// restoring division, one dividend bit per cycle, returns dividend % divisor
// ----------------------------------------------------------------------------
module tohlc_rem
  import tohlc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  rem_req_t req_i,
  output rem_rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(TimeW);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [TimeW-1:0]   dvd_q, dvd_d;
  logic [PeriodW-1:0] rem_q, rem_d;
  logic [PeriodW-1:0] dsr_q, dsr_d;

  logic [PeriodW:0]   trial;
  logic [PeriodW+1:0] diff;

  assign trial = {rem_q, dvd_q[TimeW-1]};
  assign diff  = {1'b0, trial} - {2'b00, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      dvd_d = {dvd_q[TimeW-2:0], 1'b0};
      // keep the difference when the trial value is not below the divisor
      rem_d = diff[PeriodW+1] ? trial[PeriodW-1:0] : diff[PeriodW-1:0];
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(TimeW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ----- rtl/tick_to_ohlc_bar_aggregator.sv -----
// ----------------------------------------------------------------------------
// tick_to_ohlc_bar_aggregator: folds market ticks into ohlc bars
// one result item per tick item, a snapshot of the current bar
// ----------------------------------------------------------------------------
// a dropped tick passes through the check and emit states, a tick inside
//   the open bar through check, apply and emit, a tick opening a bar also waits on the remainder unit
// one item at a time: the next item is taken once
//   the result is in the output register
// reset: asynchronous active low, no bar open, period 60000, source last
module tick_to_ohlc_bar_aggregator
  import tohlc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [TimeW-1:0]    tick_time_i,
  input  logic [PriceW-1:0]   last_price_i,
  input  logic [PriceW-1:0]   mid_price_i,
  input  logic [PriceW-1:0]   bid_price_i,
  input  logic [PriceW-1:0]   ask_price_i,
  input  logic [TickVolW-1:0] tick_volume_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                accepted_o,
  output logic                new_bar_o,
  output logic                closed_previous_o,
  output logic [TimeW-1:0]    bar_start_o,
  output logic [PriceW-1:0]   open_price_o,
  output logic [PriceW-1:0]   high_price_o,
  output logic [PriceW-1:0]   low_price_o,
  output logic [PriceW-1:0]   close_price_o,
  output logic [BarVolW-1:0]  bar_volume_o
);

  state_e state_q, state_d;

  // configuration
  logic [PeriodW-1:0] period_q;
  src_e               src_q;

  // latched item
  logic [TimeW-1:0]    t_q;
  logic [PriceW-1:0]   price_q;
  logic [TickVolW-1:0] vol_q;
  logic                acc_q, acc_d;
  logic                open_q, open_d;
  logic                closed_q, closed_d;

  // bar state
  logic                active_q;
  logic [TimeW-1:0]    last_seen_q;
  logic [TimeW-1:0]    start_q;
  logic [PriceW-1:0]   o_q, h_q, l_q, c_q;
  logic [BarVolW-1:0]  bvol_q;

  // output register
  logic                out_valid_q, out_valid_d;

  logic                in_acc;
  logic                load_out;
  logic                apply;
  logic [PriceW-1:0]   price_sel;
  logic [PeriodW-1:0]  period_eff;
  logic [TimeW:0]      bar_end;
  logic                drop;
  logic                close_now;
  logic [BarVolW-1:0]  base_vol;
  logic [BarVolW:0]    vol_sum;
  logic [BarVolW-1:0]  vol_next;
  logic [PriceW-1:0]   base_h, base_l;

  rem_req_t rem_req;
  rem_rsp_t rem_rsp;

  tohlc_rem u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rem_req),
    .rsp_o  (rem_rsp)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    unique case (src_q)
      SRC_LAST: price_sel = last_price_i;
      SRC_MID:  price_sel = mid_price_i;
      SRC_BID:  price_sel = bid_price_i;
      SRC_ASK:  price_sel = ask_price_i;
      default:  price_sel = last_price_i;
    endcase
  end

  // a zero period counts as one
  assign period_eff = (period_q == '0) ? PeriodW'(1) : period_q;
  assign bar_end    = {1'b0, start_q} + (TimeW + 1)'(period_eff);
  assign drop       = (t_q <= last_seen_q);
  assign close_now  = active_q && ({1'b0, t_q} >= bar_end);

  // saturating volume fold
  assign base_vol = open_q ? '0 : bvol_q;
  assign vol_sum  = {1'b0, base_vol} + (BarVolW + 1)'(vol_q);
  assign vol_next = vol_sum[BarVolW] ? '1 : vol_sum[BarVolW-1:0];
  assign base_h   = open_q ? price_q : h_q;
  assign base_l   = open_q ? price_q : l_q;

  always_comb begin
    state_d          = state_q;
    acc_d            = acc_q;
    open_d           = open_q;
    closed_d         = closed_q;
    rem_req.start    = 1'b0;
    rem_req.dividend = t_q;
    rem_req.divisor  = period_eff;
    apply            = 1'b0;
    load_out         = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        acc_d    = !drop;
        closed_d = !drop && close_now;
        open_d   = !drop && (!active_q || close_now);
        if (drop) begin
          state_d = ST_EMIT;
        end else if (!active_q || close_now) begin
          rem_req.start = 1'b1;
          state_d       = ST_DIV;
        end else begin
          state_d = ST_APPLY;
        end
      end
      ST_DIV: begin
        if (rem_rsp.done) begin
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: begin
        apply   = 1'b1;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      period_q    <= PeriodReset;
      src_q       <= SRC_LAST;
      acc_q       <= 1'b0;
      open_q      <= 1'b0;
      closed_q    <= 1'b0;
      active_q    <= 1'b0;
      last_seen_q <= '0;
      start_q     <= '0;
      o_q         <= '0;
      h_q         <= '0;
      l_q         <= '0;
      c_q         <= '0;
      bvol_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      acc_q       <= acc_d;
      open_q      <= open_d;
      closed_q    <= closed_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgBarPeriod:   period_q <= cfg_wdata_i[PeriodW-1:0];
          CfgPriceSource: src_q    <= src_e'(cfg_wdata_i[SrcW-1:0]);
          default: ;
        endcase
      end
      if (apply) begin
        active_q    <= 1'b1;
        last_seen_q <= t_q;
        if (open_q) begin
          // bar opens at the tick time rounded down to the period
          start_q <= t_q - TimeW'(rem_rsp.rem);
          o_q     <= price_q;
        end
        h_q    <= (price_q > base_h) ? price_q : base_h;
        l_q    <= (price_q < base_l) ? price_q : base_l;
        c_q    <= price_q;
        bvol_q <= vol_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      t_q     <= tick_time_i;
      price_q <= price_sel;
      vol_q   <= tick_volume_i;
    end
  end

  logic                acc_out_q, open_out_q, closed_out_q;
  logic [TimeW-1:0]    start_out_q;
  logic [PriceW-1:0]   o_out_q, h_out_q, l_out_q, c_out_q;
  logic [BarVolW-1:0]  vol_out_q;

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      acc_out_q    <= acc_q;
      open_out_q   <= open_q;
      closed_out_q <= closed_q;
      start_out_q  <= start_q;
      o_out_q      <= o_q;
      h_out_q      <= h_q;
      l_out_q      <= l_q;
      c_out_q      <= c_q;
      vol_out_q    <= bvol_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign accepted_o        = acc_out_q;
  assign new_bar_o         = open_out_q;
  assign closed_previous_o = closed_out_q;
  assign bar_start_o       = start_out_q;
  assign open_price_o      = o_out_q;
  assign high_price_o      = h_out_q;
  assign low_price_o       = l_out_q;
  assign close_price_o     = c_out_q;
  assign bar_volume_o      = vol_out_q;

endmodule

// ----- rtl/tohlc_checker.sv -----
// ----------------------------------------------------------------------------
// tohlc_checker: port-level checks of the aggregator
// handshake hold, one item in flight and consistency of the bar snapshot
// ----------------------------------------------------------------------------
module tohlc_checker
  import tohlc_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic               accepted_o,
  input logic               new_bar_o,
  input logic               closed_previous_o,
  input logic [PriceW-1:0]  high_price_o,
  input logic [PriceW-1:0]  low_price_o,
  input logic [PriceW-1:0]  close_price_o,
  input logic [BarVolW-1:0] bar_volume_o
);

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(accepted_o) && $stable(close_price_o)
      && $stable(bar_volume_o))
    else $error("result item changed while stalled");

  // busy after taking an item
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after an accepted item");

  // a dropped tick neither opens nor closes
  a_drop_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !accepted_o |-> !new_bar_o && !closed_previous_o)
    else $error("dropped tick flagged a bar change");

  // closing a bar always opens the next one
  a_close_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && closed_previous_o |-> new_bar_o)
    else $error("bar closed without a new one");

  // close lies within low and high of an active bar
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && accepted_o |->
      low_price_o <= close_price_o && close_price_o <= high_price_o)
    else $error("close outside low / high range");

endmodule

bind tick_to_ohlc_bar_aggregator tohlc_checker u_tohlc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .accepted_o        (accepted_o),
  .new_bar_o         (new_bar_o),
  .closed_previous_o (closed_previous_o),
  .high_price_o      (high_price_o),
  .low_price_o       (low_price_o),
  .close_price_o     (close_price_o),
  .bar_volume_o      (bar_volume_o)
);

// ----- tb/tb_tick_to_ohlc_bar_aggregator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tick_to_ohlc_bar_aggregator: self-checking bench for the ohlc bar folder
// ticks go in through a queue-fed driver and bar snapshots come back through a
// monitor. Each snapshot is checked against a bar predictor that runs on every
// accepted tick. The run covers stale ticks, all price sources, period changes
// with a bar open, a zero period, a burst of full-volume ticks and the top of
// the time range. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module tb_tick_to_ohlc_bar_aggregator;
  import tohlc_pkg::*;

  localparam logic [TimeW-1:0]   TimeMax    = '1;
  localparam logic [BarVolW-1:0] VolMax     = '1;
  localparam logic [PeriodW-1:0] PeriodMax  = '1;
  localparam int unsigned        BurstTicks = 64;

  typedef struct packed {
    logic [TimeW-1:0]    stamp;
    logic [PriceW-1:0]   last_px;
    logic [PriceW-1:0]   mid_px;
    logic [PriceW-1:0]   bid_px;
    logic [PriceW-1:0]   ask_px;
    logic [TickVolW-1:0] vol;
  } tick_t;

  typedef struct packed {
    logic                accepted;
    logic                new_bar;
    logic                closed_prev;
    logic [TimeW-1:0]    start_t;
    logic [PriceW-1:0]   open_px;
    logic [PriceW-1:0]   high_px;
    logic [PriceW-1:0]   low_px;
    logic [PriceW-1:0]   close_px;
    logic [BarVolW-1:0]  volume;
  } bar_snap_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = CfgBarPeriod;
  logic [CfgDataW-1:0] cfg_wdata_i   = '0;
  logic                in_valid_i    = 1'b0;
  logic                in_ready_o;
  logic [TimeW-1:0]    tick_time_i   = '0;
  logic [PriceW-1:0]   last_price_i  = '0;
  logic [PriceW-1:0]   mid_price_i   = '0;
  logic [PriceW-1:0]   bid_price_i   = '0;
  logic [PriceW-1:0]   ask_price_i   = '0;
  logic [TickVolW-1:0] tick_volume_i = '0;
  logic                out_valid_o;
  logic                out_ready_i   = 1'b0;
  logic                accepted_o;
  logic                new_bar_o;
  logic                closed_previous_o;
  logic [TimeW-1:0]    bar_start_o;
  logic [PriceW-1:0]   open_price_o;
  logic [PriceW-1:0]   high_price_o;
  logic [PriceW-1:0]   low_price_o;
  logic [PriceW-1:0]   close_price_o;
  logic [BarVolW-1:0]  bar_volume_o;

  tick_to_ohlc_bar_aggregator dut (.*);

  always #10 clk_i = ~clk_i;

  tick_t     pending_ticks[$];
  bar_snap_t bar_snaps[$];
  int        errors = 0;
  bit        rush   = 1'b0;

  // bar predictor state and its copy of the registers
  logic [PeriodW-1:0] period_cfg = PeriodReset;
  src_e               source_cfg = SRC_LAST;
  logic [TimeW-1:0]   seen_time  = '0;
  logic               bar_open   = 1'b0;
  logic [TimeW-1:0]   bar_t0     = '0;
  logic [PriceW-1:0]  bar_o      = '0;
  logic [PriceW-1:0]  bar_h      = '0;
  logic [PriceW-1:0]  bar_l      = '0;
  logic [PriceW-1:0]  bar_c      = '0;
  logic [BarVolW-1:0] bar_vol    = '0;

  // newest time handed to the driver so far
  logic [TimeW-1:0]   gen_last   = '0;

  function automatic void fold_tick(tick_t tk);
    logic [PriceW-1:0]  px;
    logic [PeriodW-1:0] per;
    logic [TimeW:0]     bar_end;
    logic [BarVolW:0]   vsum;
    bar_snap_t          s;
    per = (period_cfg == '0) ? PeriodW'(1) : period_cfg;
    s = '0;
    if (tk.stamp > seen_time) begin
      case (source_cfg)
        SRC_LAST: px = tk.last_px;
        SRC_MID:  px = tk.mid_px;
        SRC_BID:  px = tk.bid_px;
        default:  px = tk.ask_px;
      endcase
      // bar end is one bit wider so it cannot wrap
      bar_end = {1'b0, bar_t0} + (TimeW+1)'(per);
      if (bar_open && {1'b0, tk.stamp} >= bar_end) begin
        bar_open = 1'b0;
        s.closed_prev = 1'b1;
      end
      if (!bar_open) begin
        bar_open = 1'b1;
        s.new_bar = 1'b1;
        bar_t0 = tk.stamp - (tk.stamp % TimeW'(per));
        bar_o = px;
        bar_h = px;
        bar_l = px;
        bar_c = px;
        bar_vol = '0;
      end
      vsum = {1'b0, bar_vol} + (BarVolW+1)'(tk.vol);
      bar_vol = (vsum > {1'b0, VolMax}) ? VolMax : vsum[BarVolW-1:0];
      if (px > bar_h) bar_h = px;
      if (px < bar_l) bar_l = px;
      bar_c = px;
      seen_time = tk.stamp;
      s.accepted = 1'b1;
    end
    s.start_t  = bar_t0;
    s.open_px  = bar_o;
    s.high_px  = bar_h;
    s.low_px   = bar_l;
    s.close_px = bar_c;
    s.volume   = bar_vol;
    bar_snaps.push_back(s);
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic void push_tick(input logic [TimeW-1:0] t,
                                    input logic [PriceW-1:0] lp, mp, bp, ap,
                                    input logic [TickVolW-1:0] v);
    tick_t tk;
    tk = '{stamp: t, last_px: lp, mid_px: mp, bid_px: bp, ask_px: ap, vol: v};
    if (t > gen_last) gen_last = t;
    pending_ticks.push_back(tk);
  endfunction

  function automatic void push_rand(logic [TimeW-1:0] t);
    push_tick(t, rand_word(), rand_word(), rand_word(), rand_word(), rand_word());
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgBarPeriod) period_cfg = data;
    else source_cfg = src_e'(data[SrcW-1:0]);
  endtask

  // sampled on the falling edge so the driver's updates have settled
  task automatic drain(int settle);
    do @(negedge clk_i);
    while (pending_ticks.size() != 0 || in_valid_i || bar_snaps.size() != 0);
    repeat (settle) @(negedge clk_i);
  endtask

  // tick driver
  int gap_left = 0;
  bit in_calm  = 1'b0;

  always @(posedge clk_i) begin
    tick_t tk;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left   <= 0;
    end else begin
      if (in_valid_i && in_ready_o)
        fold_tick(tick_t'({tick_time_i, last_price_i, mid_price_i, bid_price_i,
                           ask_price_i, tick_volume_i}));
      if (in_valid_i && !in_ready_o) begin
        // item still waiting, hold it
      end else if (gap_left > 0) begin
        in_valid_i <= 1'b0;
        gap_left   <= gap_left - 1;
      end else if (pending_ticks.size() != 0) begin
        tk = pending_ticks.pop_front();
        tick_time_i   <= tk.stamp;
        last_price_i  <= tk.last_px;
        mid_price_i   <= tk.mid_px;
        bid_price_i   <= tk.bid_px;
        ask_price_i   <= tk.ask_px;
        tick_volume_i <= tk.vol;
        in_valid_i    <= 1'b1;
        if ($urandom_range(0, 24) == 0) in_calm = !in_calm;
        gap_left <= (rush || in_calm) ? 0 : $urandom_range(0, 5);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // snapshot monitor
  int stall_left = 0;
  bit out_calm   = 1'b0;

  always @(posedge clk_i) begin
    bar_snap_t want;
    int n;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left  <= 0;
    end else if (out_valid_o && out_ready_i) begin
      if (bar_snaps.size() == 0) begin
        errors++;
        $display("%0t: bar snapshot with no tick waiting for it", $time);
      end else begin
        want = bar_snaps.pop_front();
        check_field("accepted", 64'(want.accepted), 64'(accepted_o));
        check_field("new_bar", 64'(want.new_bar), 64'(new_bar_o));
        check_field("closed_previous", 64'(want.closed_prev), 64'(closed_previous_o));
        check_field("bar_start", 64'(want.start_t), 64'(bar_start_o));
        check_field("open_price", 64'(want.open_px), 64'(open_price_o));
        check_field("high_price", 64'(want.high_px), 64'(high_price_o));
        check_field("low_price", 64'(want.low_px), 64'(low_price_o));
        check_field("close_price", 64'(want.close_px), 64'(close_price_o));
        check_field("bar_volume", 64'(want.volume), 64'(bar_volume_o));
      end
      if ($urandom_range(0, 24) == 0) out_calm = !out_calm;
      n = (rush || out_calm) ? 0 : $urandom_range(0, 5);
      stall_left  <= n;
      out_ready_i <= (n == 0);
    end else if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= (stall_left == 1);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  initial begin
    logic [PeriodW-1:0] per;
    logic [63:0]        pe;
    logic [63:0]        span;
    logic [63:0]        rnd;
    logic [TimeW-1:0]   t;
    int                 r;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // no bar yet: a tick at time zero is stale against the reset time
    push_rand('0);
    push_tick(48'd1000, 32'd100, 32'd200, 32'd300, 32'd400, 32'd5);
    push_rand(48'd1000);
    push_rand(48'd500);
    push_tick(48'd2000, '1, '1, '1, '1, '0);
    push_tick(48'd3000, '0, '0, '0, '0, '1);
    push_rand(48'd59999);
    push_rand(48'd60000);
    push_rand(48'd130001);
    drain(4);

    write_reg(CfgPriceSource, CfgDataW'(SRC_MID));
    write_reg(CfgBarPeriod, 32'd1);
    push_rand(48'd130002);
    push_rand(48'd130003);
    drain(4);

    // zero period behaves as one
    write_reg(CfgPriceSource, CfgDataW'(SRC_BID));
    write_reg(CfgBarPeriod, '0);
    push_rand(48'd130005);
    push_rand(48'd130006);
    drain(4);

    // longer period with a bar open: the bar keeps its start
    write_reg(CfgPriceSource, CfgDataW'(SRC_ASK));
    write_reg(CfgBarPeriod, PeriodMax);
    push_rand(48'd130007);
    push_rand(48'd4295097303);

    for (int ph = 0; ph < 6; ph++) begin
      drain(4);
      case (ph)
        0: per = 32'd1;
        1: per = 32'd60000;
        2: per = $urandom_range(2, 200);
        3: per = PeriodMax;
        4: per = $urandom;
        default: per = '0;
      endcase
      write_reg(CfgBarPeriod, per);
      write_reg(CfgPriceSource, $urandom);
      pe = (per == '0) ? 64'd1 : 64'(per);
      span = (pe / 8 == 0) ? 64'd1 : pe / 8;
      for (int i = 0; i < 235; i++) begin
        r = $urandom_range(0, 99);
        rnd = {$urandom, $urandom};
        if (r < 10) begin
          // stale: the same time again or anything older
          if ($urandom_range(0, 1) == 0) t = gen_last;
          else t = TimeW'(rnd % (64'(gen_last) + 64'd1));
        end else if (r < 75) begin
          t = TimeW'(64'(gen_last) + 64'd1 + rnd % span);
        end else if (r < 95) begin
          t = TimeW'(64'(gen_last) + pe + rnd % pe);
        end else begin
          t = TimeW'(64'(gen_last) + rnd % 64'h10_0000_0000);
        end
        push_rand(t);
      end
    end

    // one long bar of back-to-back full-volume ticks
    drain(4);
    write_reg(CfgBarPeriod, PeriodMax);
    write_reg(CfgPriceSource, CfgDataW'(SRC_LAST));
    rush = 1'b1;
    t = (gen_last / TimeW'(PeriodMax) + 1) * TimeW'(PeriodMax);
    for (int i = 0; i < BurstTicks; i++)
      push_tick(t + TimeW'(i), $urandom, $urandom, $urandom, $urandom, '1);
    drain(4);
    rush = 1'b0;

    // top of the time range, bar end runs past the time width
    write_reg(CfgPriceSource, $urandom);
    push_rand(TimeMax - 48'h2_0000_0000);
    push_rand(TimeMax - 48'd3);
    push_rand(TimeMax);
    push_rand(TimeMax);
    for (int i = 0; i < 8; i++) begin
      rnd = {$urandom, $urandom};
      push_rand(rnd[TimeW-1:0]);
    end
    drain(60);

    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #60_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
